// ----- design/eed_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the ElGamal engine.
package eed_pkg;

    // Width of every field word on the ports.
    localparam int FIELD_W = 32;

    // Default internal datapath width.
    localparam int WIDTH_DEF = 32;

    // Register reset values.
    localparam logic [FIELD_W-1:0] MODULUS_RST     = 32'd1229;
    localparam logic [FIELD_W-1:0] GENERATOR_RST   = 32'd2;
    localparam logic [FIELD_W-1:0] PRIVATE_KEY_RST = 32'd1097;
    localparam logic [FIELD_W-1:0] PUBLIC_KEY_RST  = 32'd1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_KEY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_KEY  = 2'd3;

    // Command codes of an input word.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Modular multiplication jobs: each fixes operands and destination.
    typedef enum logic [2:0] {
        OP_RED_MSG,
        OP_RED_C2,
        OP_RED_G,
        OP_RED_Y,
        OP_RED_C1,
        OP_POW_MUL,
        OP_POW_SQR,
        OP_FINAL
    } t_op;

    // Controller to datapath.
    typedef struct packed {
        logic mul_start;
        t_op  op;
        logic init_pow;
        logic shift_exp;
        logic save_first;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic mul_done;
        logic exp_zero;
        logic exp_lsb;
        logic mod_zero;
        logic is_decrypt;
    } t_stat;

endpackage

// ----- design/eed_datapath.sv -----
// Datapath of the ElGamal engine: registers, operand selection and a shift-and-add modular multiplier.
module eed_datapath #(
    parameter int WIDTH = eed_pkg::WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_capture,
    input  logic                              i_command,
    input  logic [eed_pkg::FIELD_W-1:0]       i_message,
    input  logic [eed_pkg::FIELD_W-1:0]       i_nonce,
    input  logic [eed_pkg::FIELD_W-1:0]       i_first_cipher,
    input  logic [eed_pkg::FIELD_W-1:0]       i_second_cipher,
    input  logic                              i_cfg_write,
    input  logic [eed_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [eed_pkg::FIELD_W-1:0]       i_cfg_data,
    input  eed_pkg::t_cmd                     i_cmd,
    output eed_pkg::t_stat                    o_stat,
    output logic [eed_pkg::FIELD_W-1:0]       o_first_result,
    output logic [eed_pkg::FIELD_W-1:0]       o_second_result
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    // Configuration registers.
    logic [WIDTH-1:0] r_p, r_g, r_x, r_y;
    // Captured input word.
    logic             r_dec;
    logic [WIDTH-1:0] r_msg, r_nonce, r_c1, r_c2;
    // Working registers.
    logic [WIDTH-1:0] r_m, r_sq, r_pacc, r_exp, r_res0, r_res1;
    // Multiplier state.
    logic [WIDTH-1:0] r_acc, r_ma, r_mb;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ph, r_mbusy, r_mdone;
    eed_pkg::t_op     r_op;

    logic [WIDTH-1:0] one_val, dec_exp, add_y, n_acc, sel_a, sel_b;
    logic [WIDTH:0]   add_sum;
    logic             advance, finish;

    // One reduced modulo p: zero when p is one.
    assign one_val = WIDTH'(r_p != WIDTH'(1));

    // Decrypt exponent p-1-x, saturating at zero when x is not below p.
    assign dec_exp = (r_x < r_p) ? (r_p - WIDTH'(1) - r_x) : '0;

    // Modular add of two reduced values: doubling in phase zero, adding the multiplicand after.
    assign add_y   = r_ph ? r_ma : r_acc;
    assign add_sum = {1'b0, r_acc} + {1'b0, add_y};
    assign n_acc   = (add_sum >= {1'b0, r_p}) ? WIDTH'(add_sum - {1'b0, r_p}) : add_sum[WIDTH-1:0];

    // A multiplier bit is done after doubling when it is clear, or after the add.
    assign advance = r_mbusy && (r_ph || !r_mb[WIDTH-1]);
    assign finish  = advance && (r_cnt == CNT_W'(1));

    // Operand selection per job.
    always_comb begin
        sel_a = one_val;
        sel_b = r_msg;
        unique case (i_cmd.op)
            eed_pkg::OP_RED_MSG: begin sel_a = one_val; sel_b = r_msg; end
            eed_pkg::OP_RED_C2:  begin sel_a = one_val; sel_b = r_c2;  end
            eed_pkg::OP_RED_G:   begin sel_a = one_val; sel_b = r_g;   end
            eed_pkg::OP_RED_Y:   begin sel_a = one_val; sel_b = r_y;   end
            eed_pkg::OP_RED_C1:  begin sel_a = one_val; sel_b = r_c1;  end
            eed_pkg::OP_POW_MUL: begin sel_a = r_pacc;  sel_b = r_sq;  end
            eed_pkg::OP_POW_SQR: begin sel_a = r_sq;    sel_b = r_sq;  end
            eed_pkg::OP_FINAL:   begin sel_a = r_m;     sel_b = r_pacc; end
            default:             begin sel_a = one_val; sel_b = r_msg; end
        endcase
    end

    // Configuration registers and multiplier control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p     <= WIDTH'(eed_pkg::MODULUS_RST);
            r_g     <= WIDTH'(eed_pkg::GENERATOR_RST);
            r_x     <= WIDTH'(eed_pkg::PRIVATE_KEY_RST);
            r_y     <= WIDTH'(eed_pkg::PUBLIC_KEY_RST);
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    eed_pkg::CFG_MODULUS:     r_p <= WIDTH'(i_cfg_data);
                    eed_pkg::CFG_GENERATOR:   r_g <= WIDTH'(i_cfg_data);
                    eed_pkg::CFG_PRIVATE_KEY: r_x <= WIDTH'(i_cfg_data);
                    eed_pkg::CFG_PUBLIC_KEY:  r_y <= WIDTH'(i_cfg_data);
                    default: ;
                endcase
            end
            r_mdone <= finish;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
            end else if (finish) begin
                r_mbusy <= 1'b0;
            end
        end
    end

    // Multiplier iteration: one modular add per cycle, multiplier bits from the top.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_acc <= '0;
            r_ma  <= sel_a;
            r_mb  <= sel_b;
            r_cnt <= CNT_W'(WIDTH);
            r_ph  <= 1'b0;
            r_op  <= i_cmd.op;
        end else if (r_mbusy) begin
            r_acc <= n_acc;
            if (advance) begin
                r_ph  <= 1'b0;
                r_mb  <= r_mb << 1;
                r_cnt <= r_cnt - CNT_W'(1);
            end else begin
                r_ph  <= 1'b1;
            end
        end
    end

    // Input capture, exponent handling and product write-back.
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_dec   <= i_command;
            r_msg   <= WIDTH'(i_message);
            r_nonce <= WIDTH'(i_nonce);
            r_c1    <= WIDTH'(i_first_cipher);
            r_c2    <= WIDTH'(i_second_cipher);
            r_res0  <= '0;
            r_res1  <= '0;
        end
        if (i_cmd.init_pow) begin
            r_pacc <= one_val;
            r_exp  <= (r_dec == eed_pkg::CMD_DECRYPT) ? dec_exp : r_nonce;
        end else if (i_cmd.shift_exp) begin
            r_exp  <= r_exp >> 1;
        end
        if (i_cmd.save_first) begin
            r_res0 <= r_pacc;
        end
        if (finish) begin
            unique case (r_op)
                eed_pkg::OP_RED_MSG, eed_pkg::OP_RED_C2: r_m <= n_acc;
                eed_pkg::OP_RED_G, eed_pkg::OP_RED_Y, eed_pkg::OP_RED_C1,
                eed_pkg::OP_POW_SQR: r_sq <= n_acc;
                eed_pkg::OP_POW_MUL: r_pacc <= n_acc;
                eed_pkg::OP_FINAL: begin
                    if (r_dec == eed_pkg::CMD_DECRYPT) begin
                        r_res0 <= n_acc;
                    end else begin
                        r_res1 <= n_acc;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.mul_done   = r_mdone;
    assign o_stat.exp_zero   = (r_exp == '0);
    assign o_stat.exp_lsb    = r_exp[0];
    assign o_stat.mod_zero   = (r_p == '0);
    assign o_stat.is_decrypt = (r_dec == eed_pkg::CMD_DECRYPT);

    assign o_first_result  = eed_pkg::FIELD_W'(r_res0);
    assign o_second_result = eed_pkg::FIELD_W'(r_res1);

endmodule

// ----- design/eed_control.sv -----
// Sequencer of the ElGamal engine: orders reductions, exponentiations and the final product.
module eed_control (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  eed_pkg::t_stat i_stat,
    output eed_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_OPND,
        S_RED_BASE,
        S_POW_GAP,
        S_POW_CHK,
        S_POW_MUL,
        S_POW_SQR,
        S_FINAL
    } t_state;

    t_state        r_state, n_state;
    logic          r_wait, n_wait;
    logic          r_pass, n_pass;
    logic          r_done, n_done;
    eed_pkg::t_cmd r_cmd, n_cmd;

    // Launch a job on entry to a multiply state, then wait for its completion.
    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        n_pass  = r_pass;
        n_done  = 1'b0;
        n_cmd   = '0;
        n_cmd.op = eed_pkg::OP_RED_MSG;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_pass = 1'b0;
                    if (i_stat.mod_zero) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = S_RED_OPND;
                    end
                end
            end
            S_RED_OPND: begin
                n_cmd.op = i_stat.is_decrypt ? eed_pkg::OP_RED_C2 : eed_pkg::OP_RED_MSG;
                if (!r_wait) begin
                    n_cmd.mul_start = 1'b1;
                    n_wait = 1'b1;
                end else if (i_stat.mul_done) begin
                    n_wait  = 1'b0;
                    n_state = S_RED_BASE;
                end
            end
            S_RED_BASE: begin
                n_cmd.op = i_stat.is_decrypt ? eed_pkg::OP_RED_C1 :
                           (r_pass ? eed_pkg::OP_RED_Y : eed_pkg::OP_RED_G);
                if (!r_wait) begin
                    n_cmd.mul_start = 1'b1;
                    n_wait = 1'b1;
                end else if (i_stat.mul_done) begin
                    n_wait = 1'b0;
                    n_cmd.init_pow = 1'b1;
                    n_state = S_POW_GAP;
                end
            end
            S_POW_GAP: begin
                n_state = S_POW_CHK;
            end
            S_POW_CHK: begin
                if (i_stat.exp_zero) begin
                    if (!i_stat.is_decrypt && !r_pass) begin
                        n_cmd.save_first = 1'b1;
                        n_pass  = 1'b1;
                        n_state = S_RED_BASE;
                    end else begin
                        n_state = S_FINAL;
                    end
                end else if (i_stat.exp_lsb) begin
                    n_state = S_POW_MUL;
                end else begin
                    n_state = S_POW_SQR;
                end
            end
            S_POW_MUL: begin
                n_cmd.op = eed_pkg::OP_POW_MUL;
                if (!r_wait) begin
                    n_cmd.mul_start = 1'b1;
                    n_wait = 1'b1;
                end else if (i_stat.mul_done) begin
                    n_wait  = 1'b0;
                    n_state = S_POW_SQR;
                end
            end
            S_POW_SQR: begin
                n_cmd.op = eed_pkg::OP_POW_SQR;
                if (!r_wait) begin
                    n_cmd.mul_start = 1'b1;
                    n_wait = 1'b1;
                end else if (i_stat.mul_done) begin
                    n_wait = 1'b0;
                    n_cmd.shift_exp = 1'b1;
                    n_state = S_POW_GAP;
                end
            end
            S_FINAL: begin
                n_cmd.op = eed_pkg::OP_FINAL;
                if (!r_wait) begin
                    n_cmd.mul_start = 1'b1;
                    n_wait = 1'b1;
                end else if (i_stat.mul_done) begin
                    n_wait  = 1'b0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_pass  <= 1'b0;
            r_done  <= 1'b0;
            r_cmd   <= '0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_pass  <= n_pass;
            r_done  <= n_done;
            r_cmd   <= n_cmd;
        end
    end

    assign o_cmd  = r_cmd;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE)) else $error("result strobe while a word is in work");
    a_done_unsolicited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.mul_done |-> r_wait) else $error("product finished with no job waiting");
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_wait) else $error("idle while a job is pending");
    a_start_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.mul_start |-> r_wait) else $error("job launched outside a wait");
`endif

endmodule

// ----- design/elgamal_encrypt_decrypt_top.sv -----
// Top level of the ElGamal engine: sequencer, datapath and configuration port.
//
//  channel   | handshake                 | words
//  ----------+---------------------------+--------------------------------------------
//  input     | i_start, o_busy           | command, message, nonce, ciphers
//  config    | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//  result    | o_done (one-cycle strobe) | o_first_result, o_second_result
//
// A word is taken when i_start is high and o_busy low; one word is in work at a time.
// Each modular product runs on one shared shift-and-add unit, and each exponent bit also
// passes through the bit checks of the gap and check states of the sequencer.
// Encrypt needs three reductions, two powers over the nonce bits and a final product;
// decrypt needs two reductions, one power over the bits of p-1-x and a final product.
// Reset is synchronous and active low and loads the register defaults; the result strobe
// cannot be held off, and a zero modulus gives a zero result in the cycle after acceptance.
module elgamal_encrypt_decrypt_top #(
    parameter int WIDTH = eed_pkg::WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_command,
    input  logic [eed_pkg::FIELD_W-1:0]   i_message,
    input  logic [eed_pkg::FIELD_W-1:0]   i_nonce,
    input  logic [eed_pkg::FIELD_W-1:0]   i_first_cipher,
    input  logic [eed_pkg::FIELD_W-1:0]   i_second_cipher,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [eed_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [eed_pkg::FIELD_W-1:0]   i_cfg_data,
    output logic                          o_done,
    output logic [eed_pkg::FIELD_W-1:0]   o_first_result,
    output logic [eed_pkg::FIELD_W-1:0]   o_second_result
);

    eed_pkg::t_cmd  cmd;
    eed_pkg::t_stat stat;
    logic           accept;

    // Writes must be issued only while idle (not enforced); the port always takes them.
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    eed_control u_control (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_done   (o_done)
    );

    eed_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_capture       (accept),
        .i_command       (i_command),
        .i_message       (i_message),
        .i_nonce         (i_nonce),
        .i_first_cipher  (i_first_cipher),
        .i_second_cipher (i_second_cipher),
        .i_cfg_write     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_first_result  (o_first_result),
        .o_second_result (o_second_result)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the ElGamal engine: random and directed words, scoreboard check.
module testbench;

    // One command word as driven on the input ports.
    typedef struct {
        logic        cmd;
        logic [31:0] msg;
        logic [31:0] nonce;
        logic [31:0] c1;
        logic [31:0] c2;
    } t_word;

    // One result word.
    typedef struct {
        logic [31:0] first;
        logic [31:0] second;
    } t_res;

    localparam int WATCHDOG_LIMIT = 100000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cmd = 1'b0;
    logic [31:0] msg = '0, nonce = '0, c1 = '0, c2 = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = eed_pkg::CFG_MODULUS;
    logic [31:0] cfg_data = '0;
    logic        done;
    logic [31:0] first_res, second_res;

    // Model copy of the registers.
    logic [31:0] p_reg = eed_pkg::MODULUS_RST;
    logic [31:0] g_reg = eed_pkg::GENERATOR_RST;
    logic [31:0] x_reg = eed_pkg::PRIVATE_KEY_RST;
    logic [31:0] y_reg = eed_pkg::PUBLIC_KEY_RST;

    t_word pending_words[$];
    t_res  expected_results[$];
    int    error_count = 0;
    int    idle_percent = 0;
    int    watchdog = 0;
    bit    stim_done = 1'b0;

    elgamal_encrypt_decrypt_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_command(cmd), .i_message(msg), .i_nonce(nonce),
        .i_first_cipher(c1), .i_second_cipher(c2),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_done(done), .o_first_result(first_res), .o_second_result(second_res)
    );

    always #5 clk = ~clk;

    // Modular product; operands below m, m nonzero.
    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] prod;
        prod = a * b;
        return 64'(prod % m);
    endfunction

    // Right-to-left square-and-multiply power.
    function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e,
                                           logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 1 % m;
        sq = base % m;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, sq, m);
            sq = mulmod(sq, sq, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Expected ciphertext or plaintext for one word under the current registers.
    function automatic t_res elgamal_predict(t_word w);
        t_res r;
        logic [63:0] p;
        logic [63:0] e;
        p = p_reg;
        r.first = '0;
        r.second = '0;
        if (p != 0) begin
            if (w.cmd == eed_pkg::CMD_ENCRYPT) begin
                r.first = 32'(powmod(g_reg, w.nonce, p));
                r.second = 32'(mulmod(w.msg % p, powmod(y_reg, w.nonce, p), p));
            end else begin
                e = (x_reg <= p - 1) ? p - 1 - x_reg : 0;
                r.first = 32'(mulmod(w.c2 % p, powmod(w.c1, e, p), p));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: presents queued words, with random gaps.
    always @(negedge clk) begin
        if (start && !busy) begin
            // handshake completed at the last rising edge; handled in monitor
        end
        if (rst_n && pending_words.size() > 0 && !(start && busy) &&
            $urandom_range(99) >= idle_percent) begin
            start <= 1'b1;
            cmd <= pending_words[0].cmd;
            msg <= pending_words[0].msg;
            nonce <= pending_words[0].nonce;
            c1 <= pending_words[0].c1;
            c2 <= pending_words[0].c2;
        end else if (!(start && busy)) begin
            start <= 1'b0;
        end
    end

    // Monitor: predicts at acceptance and checks each result strobe.
    always @(posedge clk) begin
        t_word w;
        t_res  want;
        bit    progress;
        progress = 1'b0;
        if (rst_n) begin
            if (start && !busy) begin
                w = pending_words.pop_front();
                expected_results.push_back(elgamal_predict(w));
                progress = 1'b1;
            end
            if (done) begin
                progress = 1'b1;
                if (expected_results.size() == 0) begin
                    $display("unexpected result word at %0t", $realtime);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (first_res !== want.first)
                        report_mismatch("first_result", first_res, want.first);
                    if (second_res !== want.second)
                        report_mismatch("second_result", second_res, want.second);
                end
            end
            if (cfg_valid && cfg_ready) progress = 1'b1;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
            watchdog <= progress ? 0 : watchdog + 1;
        end
    end

    task automatic push_word(logic c, logic [31:0] m, logic [31:0] r,
                             logic [31:0] a, logic [31:0] b);
        t_word w;
        w.cmd = c; w.msg = m; w.nonce = r; w.c1 = a; w.c2 = b;
        pending_words.push_back(w);
    endtask

    // Waits until every queued word is accepted and answered, plus a drain margin.
    task automatic drain();
        while (pending_words.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Writes one register through the configuration channel while idle.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            eed_pkg::CFG_MODULUS:     p_reg = val;
            eed_pkg::CFG_GENERATOR:   g_reg = val;
            eed_pkg::CFG_PRIVATE_KEY: x_reg = val;
            default:                  y_reg = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random words: mostly in range, some raw full-width values.
    task automatic random_words(int n);
        logic [31:0] lim;
        logic [31:0] m, r, a, b;
        lim = (p_reg > 1) ? p_reg - 1 : 32'd1;
        repeat (n) begin
            if ($urandom_range(3) == 0) begin
                m = $urandom(); r = $urandom(); a = $urandom(); b = $urandom();
            end else begin
                m = $urandom_range(lim, 0);
                r = $urandom_range(lim, 1);
                a = $urandom_range(lim, 0);
                b = $urandom_range(lim, 0);
            end
            push_word($urandom_range(1), m, r, a, b);
        end
    endtask

    initial begin
        logic [31:0] gx;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset registers, field extremes, zero nonce, both commands.
        push_word(eed_pkg::CMD_ENCRYPT, 0, 0, 0, 0);
        push_word(eed_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        push_word(eed_pkg::CMD_ENCRYPT, 1228, 1, 0, 0);
        push_word(eed_pkg::CMD_ENCRYPT, 1229, 1228, 0, 0);
        push_word(eed_pkg::CMD_DECRYPT, 0, 0, 0, 0);
        push_word(eed_pkg::CMD_DECRYPT, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(eed_pkg::CMD_DECRYPT, 0, 0, 1229, 1228);
        push_word(eed_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5, 7);
        drain();

        // Key pair matching the generator, and a private key above p-1.
        write_reg(eed_pkg::CFG_PUBLIC_KEY, 32'(powmod(2, 1097, 1229)));
        push_word(eed_pkg::CMD_ENCRYPT, 77, 5, 0, 0);
        push_word(eed_pkg::CMD_DECRYPT, 0, 0, 123, 456);
        random_words(40);
        drain();
        write_reg(eed_pkg::CFG_PRIVATE_KEY, 32'hFFFF_FFFF);
        push_word(eed_pkg::CMD_DECRYPT, 0, 0, 9, 1300);
        drain();

        // Largest 32-bit prime, full-width keys, sender mostly idle.
        idle_percent = 84;
        write_reg(eed_pkg::CFG_MODULUS, 32'hFFFF_FFFB);
        write_reg(eed_pkg::CFG_GENERATOR, 32'hFFFF_FFFF);
        write_reg(eed_pkg::CFG_PRIVATE_KEY, 32'h1234_5679);
        gx = 32'(powmod(32'hFFFF_FFFF, 32'h1234_5679, 32'hFFFF_FFFB));
        write_reg(eed_pkg::CFG_PUBLIC_KEY, gx);
        push_word(eed_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFA, 0, 0);
        random_words(60);
        drain();

        // Smallest legal modulus, then the degenerate moduli zero and one.
        idle_percent = 28;
        write_reg(eed_pkg::CFG_MODULUS, 3);
        write_reg(eed_pkg::CFG_GENERATOR, 2);
        write_reg(eed_pkg::CFG_PRIVATE_KEY, 1);
        write_reg(eed_pkg::CFG_PUBLIC_KEY, 2);
        random_words(30);
        drain();
        write_reg(eed_pkg::CFG_MODULUS, 0);
        random_words(8);
        drain();
        write_reg(eed_pkg::CFG_MODULUS, 1);
        random_words(8);
        drain();

        // Random odd moduli with the top bit set, with random keys.
        idle_percent = 0;
        repeat (4) begin
            write_reg(eed_pkg::CFG_MODULUS, $urandom() | 32'h8000_0001);
            write_reg(eed_pkg::CFG_GENERATOR, $urandom_range(32'hFFFF_FFFF, 1));
            write_reg(eed_pkg::CFG_PRIVATE_KEY, $urandom_range(32'hFFFF_FFFF, 1));
            write_reg(eed_pkg::CFG_PUBLIC_KEY, $urandom());
            random_words(60);
            idle_percent = (idle_percent == 0) ? 84 : 0;
            drain();
        end

        stim_done = 1'b1;
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
design/eed_pkg.sv
design/eed_datapath.sv
design/eed_control.sv
design/elgamal_encrypt_decrypt_top.sv
tb/testbench.sv
